// ===== design/atcc_pkg.sv =====
// package for the autorange test channel controller
// shared constants, item and configuration types; no dependencies
package atcc_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int TIME_WIDTH   = 16;
  localparam int SAMPLE_WIDTH = 12;
  localparam int CHAN_W       = 3;
  localparam int STATE_W      = 2;
  localparam int TAGGED_W     = SAMPLE_WIDTH + 1;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 3;

  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 24;
  localparam int OUT_FIELD_W  = CHAN_W + STATE_W + 1 + 1 + TAGGED_W;

  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_DATA_W-1:0] UP_THR_RESET = CFG_DATA_W'(4095);
  localparam logic [CFG_DATA_W-1:0] PERIOD_RESET = CFG_DATA_W'(65535);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE_MASK = 3'd0,
    CFG_DURATION    = 3'd1,
    CFG_UP_THR      = 3'd2,
    CFG_DOWN_THR    = 3'd3,
    CFG_PERIOD      = 3'd4
  } cfg_index_t;

  typedef enum logic [STATE_W-1:0] {
    ST_OUT = 2'd0,
    ST_RUN = 2'd1,
    ST_END = 2'd2
  } test_state_t;

  typedef struct packed {
    logic [NUM_CHANNELS-1:0] enable_mask;
    logic [TIME_WIDTH-1:0]   duration;
    logic [SAMPLE_WIDTH-1:0] up_thr;
    logic [SAMPLE_WIDTH-1:0] down_thr;
    logic [TIME_WIDTH-1:0]   period;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0]       channel_index;
    logic                    device_present;
    logic [SAMPLE_WIDTH-1:0] adc_sample;
    logic [TIME_WIDTH-1:0]   time_now;
    logic                    in_range;
    logic                    enabled;
  } q_item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic [TAGGED_W-1:0] tagged_sample;
    logic                sample_valid;
    logic                range_relay;
    logic [STATE_W-1:0]  test_state;
    logic [CHAN_W-1:0]   channel_out;
  } out_item_t;

endpackage

// ===== design/atcc_front.sv =====
// front end: takes input transfers, unpacks and classifies them
// depends on atcc_pkg; feeds atcc_queue
module atcc_front import atcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [NUM_CHANNELS-1:0] enable_mask,
  input  q_status_t             q_status,
  output logic                  push,
  output q_item_t               push_item
);

  localparam int PRES_LSB = CHAN_W;
  localparam int SMP_LSB  = PRES_LSB + 1;
  localparam int TIME_LSB = SMP_LSB + SAMPLE_WIDTH;

  logic [CHAN_W-1:0] ch;
  logic              in_range;
  logic              ready_r;

  // ready registered from reset so nothing is taken while reset is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
    end else begin
      ready_r <= 1'b1;
    end
  end

  assign ch       = in_tdata[CHAN_W-1:0];
  assign in_range = ({1'b0, ch} < (CHAN_W+1)'(NUM_CHANNELS));

  assign in_tready = ready_r && !q_status.full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    push_item.channel_index  = ch;
    push_item.device_present = in_tdata[PRES_LSB];
    push_item.adc_sample     = in_tdata[SMP_LSB +: SAMPLE_WIDTH];
    push_item.time_now       = in_tdata[TIME_LSB +: TIME_WIDTH];
    push_item.in_range       = in_range;
    push_item.enabled        = in_range && enable_mask[ch];
  end

endmodule

// ===== design/atcc_queue.sv =====
// short queue between the front and back ends
// depends on atcc_pkg
module atcc_queue import atcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_item_t   push_item,
  input  logic      pop,
  output q_status_t status,
  output q_item_t   head
);

  q_item_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    logic [Q_PTR_W-1:0] r;
    if (p == Q_PTR_W'(Q_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign status.valid = (count_r != '0);
  assign status.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign head         = mem_r[rd_ptr_r];

endmodule

// ===== design/atcc_back.sv =====
// back end: per-channel test state, timing and range hysteresis
// depends on atcc_pkg; drains atcc_queue into the output register
module atcc_back import atcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  q_status_t q_status,
  input  q_item_t   head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int DIFF_W = TIME_WIDTH + 2;

  test_state_t           state_r [NUM_CHANNELS];
  logic [TIME_WIDTH-1:0] start_r [NUM_CHANNELS];
  logic                  rng_r   [NUM_CHANNELS];
  logic                  out_valid_r;
  out_item_t             out_item_r;

  test_state_t              st;
  test_state_t              st_nxt;
  logic                     rng;
  logic                     rng_nxt;
  logic                     running;
  logic                     over;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] adj;
  out_item_t                out_item_nxt;

  assign pop = q_status.valid && (!out_valid_r || out_ready);

  assign st  = state_r[head.channel_index];
  assign rng = rng_r[head.channel_index];

  // elapsed time modulo the timer period, one wrap only
  always_comb begin
    diff = $signed({2'b00, head.time_now}) - $signed({2'b00, start_r[head.channel_index]});
    adj  = diff[DIFF_W-1] ? diff + $signed({2'b00, cfg.period}) : diff;
    over = !adj[DIFF_W-1] && (adj >= $signed({2'b00, cfg.duration}));
  end

  always_comb begin
    st_nxt = st;
    if (head.enabled && head.device_present) begin
      unique case (st)
        ST_RUN:  if (over) st_nxt = ST_END;
        ST_OUT:  st_nxt = ST_RUN;
        ST_END:  st_nxt = ST_END;
        default: st_nxt = st;
      endcase
    end else begin
      st_nxt = ST_OUT;
    end
    running = head.enabled && (st_nxt == ST_RUN);
    rng_nxt = rng;
    if (running) begin
      if (rng) rng_nxt = !(head.adc_sample <= cfg.down_thr);
      else     rng_nxt = (head.adc_sample >= cfg.up_thr);
    end
  end

  always_comb begin
    out_item_nxt.channel_out = head.channel_index;
    if (head.in_range) begin
      out_item_nxt.test_state    = st_nxt;
      out_item_nxt.range_relay   = rng_nxt;
      out_item_nxt.sample_valid  = running;
      out_item_nxt.tagged_sample = running ? {rng, head.adc_sample} : '0;
    end else begin
      out_item_nxt.test_state    = ST_OUT;
      out_item_nxt.range_relay   = 1'b0;
      out_item_nxt.sample_valid  = 1'b0;
      out_item_nxt.tagged_sample = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        state_r[c] <= ST_OUT;
        start_r[c] <= '0;
        rng_r[c]   <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (pop && head.in_range) begin
        state_r[head.channel_index] <= st_nxt;
        rng_r[head.channel_index]   <= rng_nxt;
        if (head.enabled && head.device_present && (st == ST_OUT)) begin
          start_r[head.channel_index] <= head.time_now;
        end
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== design/autorange_test_channel_controller.sv =====
// top level of the autorange test channel controller
// depends on atcc_pkg, atcc_front, atcc_queue, atcc_back

// Takes one channel sample per clock while out_tready is held high and returns one
// result per sample, in order, in the cycle after it reaches the back end. The front
// end unpacks and classifies each transfer, a two-entry queue holds it, and the back
// end updates that channel's state registers and loads the output register in the
// same cycle, so sustained rate is one item per cycle while the output is not
// stalled. Output valid rises once the item has passed through the queue and the
// output register. Configuration writes are taken at any time but must only be
// issued while the block is idle.
module autorange_test_channel_controller import atcc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // channel_index, device_present, adc_sample, time_now
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // channel_out, test_state, range_relay, sample_valid, tagged_sample
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t      cfg_r;
  q_status_t q_status;
  q_item_t   push_item;
  q_item_t   head;
  logic      push;
  logic      pop;
  out_item_t out_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_mask <= '0;
      cfg_r.duration    <= '0;
      cfg_r.up_thr      <= UP_THR_RESET[SAMPLE_WIDTH-1:0];
      cfg_r.down_thr    <= '0;
      cfg_r.period      <= PERIOD_RESET[TIME_WIDTH-1:0];
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE_MASK: cfg_r.enable_mask <= cfg_wdata[NUM_CHANNELS-1:0];
        CFG_DURATION:    cfg_r.duration    <= cfg_wdata[TIME_WIDTH-1:0];
        CFG_UP_THR:      cfg_r.up_thr      <= cfg_wdata[SAMPLE_WIDTH-1:0];
        CFG_DOWN_THR:    cfg_r.down_thr    <= cfg_wdata[SAMPLE_WIDTH-1:0];
        CFG_PERIOD:      cfg_r.period      <= cfg_wdata[TIME_WIDTH-1:0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  atcc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .enable_mask (cfg_r.enable_mask),
    .q_status    (q_status),
    .push        (push),
    .push_item   (push_item)
  );

  atcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .status    (q_status),
    .head      (head)
  );

  atcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_status  (q_status),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = {(OUT_TDATA_W - OUT_FIELD_W)'(0), out_item};

  a_sample_only_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_item.sample_valid |-> out_item.test_state == ST_RUN)
    else $error("sample reported outside a running test");

  a_no_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_item.sample_valid |-> out_item.tagged_sample == '0)
    else $error("tagged sample not cleared without a sample");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_status.valid)
    else $error("back end popped an empty queue");

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for autorange_test_channel_controller: directed and random
// channel samples, per-channel state prediction, in-order result checking
// depends on atcc_pkg and the controller rtl
module testbench;
  import atcc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 240;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // channel_index, device_present, adc_sample, time_now
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // channel_out, test_state, range_relay, sample_valid, tagged_sample
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  autorange_test_channel_controller dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor state
  cfg_t                    run_cfg;
  test_state_t             chan_state [NUM_CHANNELS];
  logic [TIME_WIDTH-1:0]   start_time [NUM_CHANNELS];
  logic                    ma_range   [NUM_CHANNELS];

  logic [IN_TDATA_W-1:0]   sample_items[$];
  out_item_t               channel_reports[$];

  int  error_count = 0;
  int  checked_count = 0;
  int  recorded_count = 0;
  int  ended_count = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  int  tick = 0;
  bit  idle_on = 1'b1;

  function automatic void advance_channel(input logic [IN_TDATA_W-1:0] word);
    logic [CHAN_W-1:0]       ch;
    logic                    present;
    logic [SAMPLE_WIDTH-1:0] smp;
    logic [TIME_WIDTH-1:0]   now;
    logic                    en;
    int                      now_i;
    int                      start_i;
    int                      elapsed;
    out_item_t               res;
    ch      = word[2:0];
    present = word[3];
    smp     = word[15:4];
    now     = word[31:16];
    en      = run_cfg.enable_mask[ch];
    res     = '0;
    res.channel_out = ch;
    if (en && present) begin
      if (chan_state[ch] == ST_RUN) begin
        now_i   = int'(now);
        start_i = int'(start_time[ch]);
        elapsed = now_i - start_i;
        if (elapsed < 0) elapsed += int'(run_cfg.period);
        if (elapsed >= int'(run_cfg.duration)) chan_state[ch] = ST_END;
      end else if (chan_state[ch] == ST_OUT) begin
        start_time[ch] = now;
        chan_state[ch] = ST_RUN;
      end
    end else begin
      chan_state[ch] = ST_OUT;
    end
    if (en && chan_state[ch] == ST_RUN) begin
      res.sample_valid  = 1'b1;
      res.tagged_sample = {ma_range[ch], smp};
      if (!ma_range[ch]) begin
        if (smp >= run_cfg.up_thr) ma_range[ch] = 1'b1;
      end else if (smp <= run_cfg.down_thr) begin
        ma_range[ch] = 1'b0;
      end
    end
    res.test_state  = chan_state[ch];
    res.range_relay = ma_range[ch];
    channel_reports.push_back(res);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
             checked_count);
    error_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) advance_channel(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (sample_items.size() > 0) begin
          in_tdata  <= sample_items.pop_front();
          in_tvalid <= 1'b1;
          if (idle_on && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 12);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_item_t'(out_tdata[OUT_FIELD_W-1:0]);
        if (channel_reports.size() == 0) begin
          $display("unexpected transfer: channel %0d with nothing pending",
                   got.channel_out);
          error_count++;
        end else begin
          want = channel_reports.pop_front();
          if (got.channel_out !== want.channel_out)
            report_mismatch("channel_out", int'(got.channel_out), int'(want.channel_out));
          if (got.test_state !== want.test_state)
            report_mismatch("test_state", int'(got.test_state), int'(want.test_state));
          if (got.range_relay !== want.range_relay)
            report_mismatch("range_relay", int'(got.range_relay), int'(want.range_relay));
          if (got.sample_valid !== want.sample_valid)
            report_mismatch("sample_valid", int'(got.sample_valid),
                            int'(want.sample_valid));
          if (got.tagged_sample !== want.tagged_sample)
            report_mismatch("tagged_sample", int'(got.tagged_sample),
                            int'(want.tagged_sample));
          if (want.sample_valid) recorded_count++;
          if (want.test_state == ST_END) ended_count++;
        end
        checked_count++;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 15) == 0) recv_stall = $urandom_range(1, 12);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", channel_reports.size());
      $display("[autorange_test_channel_controller] ERROR");
      $finish;
    end
  end

  task automatic queue_sample(input int ch, input int present, input int smp,
                              input int now);
    logic [IN_TDATA_W-1:0] word;
    word = {now[TIME_WIDTH-1:0], smp[SAMPLE_WIDTH-1:0], present[0], ch[CHAN_W-1:0]};
    sample_items.push_back(word);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_items.size() != 0 || in_tvalid || channel_reports.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    case (idx)
      CFG_ENABLE_MASK: run_cfg.enable_mask = val[NUM_CHANNELS-1:0];
      CFG_DURATION:    run_cfg.duration    = val[TIME_WIDTH-1:0];
      CFG_UP_THR:      run_cfg.up_thr      = val[SAMPLE_WIDTH-1:0];
      CFG_DOWN_THR:    run_cfg.down_thr    = val[SAMPLE_WIDTH-1:0];
      CFG_PERIOD:      run_cfg.period      = val[TIME_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int mask, input int dur, input int up,
                                input int down, input int per);
    write_reg(CFG_ENABLE_MASK, mask);
    write_reg(CFG_DURATION, dur);
    write_reg(CFG_UP_THR, up);
    write_reg(CFG_DOWN_THR, down);
    write_reg(CFG_PERIOD, per);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_random(input int count);
    int smp;
    int now;
    int step_max;
    step_max = (run_cfg.duration >> 3) + 2;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 2))
        0: smp = $urandom_range(0, 4095);
        1: smp = $urandom_range(int'(run_cfg.up_thr), 4095);
        default: smp = $urandom_range(0, int'(run_cfg.down_thr));
      endcase
      if (run_cfg.period != 0)
        tick = (tick + $urandom_range(0, step_max)) % int'(run_cfg.period);
      now = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 65535) : tick;
      queue_sample($urandom_range(0, 7), int'($urandom_range(0, 9) != 0), smp, now);
    end
  endtask

  initial begin
    int mask;
    int dur;
    int per;
    int up;
    int down;
    run_cfg.enable_mask = '0;
    run_cfg.duration    = '0;
    run_cfg.up_thr      = UP_THR_RESET[SAMPLE_WIDTH-1:0];
    run_cfg.down_thr    = '0;
    run_cfg.period      = PERIOD_RESET;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      chan_state[c] = ST_OUT;
      start_time[c] = '0;
      ma_range[c]   = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: every channel disabled
    queue_sample(1, 1, 4095, 7);
    queue_sample(6, 0, 0, 65535);
    wait_drained();

    apply_settings('hFF, 5, 2000, 100, 100);
    queue_sample(0, 1, 0, 10);        // start records a sample
    queue_sample(0, 1, 4095, 12);     // go milliamp
    queue_sample(0, 1, 100, 14);      // at down threshold, back to microamp
    queue_sample(0, 1, 2000, 14);     // at up threshold
    queue_sample(0, 1, 7, 15);        // elapsed reaches duration
    queue_sample(0, 1, 7, 20);        // stays ended
    queue_sample(0, 0, 4095, 21);     // removal keeps range
    queue_sample(0, 1, 50, 98);
    queue_sample(0, 1, 51, 1);        // wrapped elapsed
    queue_sample(0, 1, 52, 3);
    queue_sample(7, 1, 4095, 65535);  // time beyond period
    queue_sample(7, 1, 4095, 65535);
    queue_sample(7, 1, 1, 0);
    wait_drained();

    // zero period and zero duration
    apply_settings('h08, 0, 0, 4095, 0);
    queue_sample(3, 1, 0, 50);
    queue_sample(3, 1, 4095, 10);     // negative difference keeps running
    queue_sample(3, 1, 5, 10);
    queue_sample(3, 1, 5, 60);
    queue_sample(2, 1, 5, 60);        // disabled channel
    queue_sample(4, 1, 5, 60);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      idle_on = (p < 6) && (p != 3);
      case (p)
        0: begin
          mask = 'hFF; dur = 40; up = 3000; down = 1000; per = 500;
        end
        2: begin
          mask = 'hFF; dur = 'hFFFF; up = 'hFFF; down = 0; per = 'hFFFF;
        end
        4: begin
          mask = 'hFF; dur = 1; up = 0; down = 'hFFF; per = 1;
        end
        5: begin
          mask = 0; dur = 0; up = 2048; down = 2047; per = 16;
        end
        default: begin
          mask = (p == 1) ? 'h5A : $urandom_range(1, 255);
          per  = $urandom_range(1, 65535);
          dur  = $urandom_range(0, (per < 400) ? per : 400);
          up   = $urandom_range(0, 4095);
          down = $urandom_range(0, 4095);
        end
      endcase
      apply_settings(mask, dur, up, down, per);
      if (p == 1) begin
        queue_random(PHASE_ITEMS / 2);
        wait_drained();
        queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        queue_random(PHASE_ITEMS);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("checked %0d results across reset and 10 register settings", checked_count);
    $display("%0d samples recorded, %0d results with a finished test", recorded_count,
             ended_count);
    if (error_count == 0 && channel_reports.size() == 0) begin
      $display("[autorange_test_channel_controller] OK");
    end else begin
      $display("[autorange_test_channel_controller] ERROR");
    end
    $finish;
  end

endmodule
